// ----- src/iyfd_pkg.sv -----
// ----------------------------------------------------------------------------
// iyfd_pkg
// Shared widths, codes and types of the imu yaw frame decoder.
// ----------------------------------------------------------------------------
package iyfd_pkg;

  localparam int RESERVED_BYTES_DEF = 4;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int TIME_W    = 32;
  localparam int REF_W     = 17;
  localparam int YAW_W     = 16;
  localparam int RAD_W     = 16;
  localparam int RATE_W    = 27;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 96;

  // divider operands: |rad diff| * 1000 fits 26 bits
  localparam int MAG_W = 16;
  localparam int DVD_W = 26;
  localparam int DVS_W = TIME_W;

  // arithmetic constants
  localparam int QUARTER_PI_Q16 = 51472;
  localparam int ROUND_HALF     = 32768;
  localparam int RATE_SCALE     = 1000;
  localparam int CALIB_FRAMES   = 7;
  localparam int PROD_W         = 33;

  // mode codes
  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_RECAL  = 2'd1;
  localparam logic [1:0] MODE_SETREF = 2'd2;

  // configuration register indexes
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h53;

  // completed frame from the parser
  typedef struct packed {
    logic             chk;
    logic             ok;
    logic [YAW_W-1:0] yaw;
  } iyfd_frame_t;

endpackage

// ----- src/iyfd_parser.sv -----
// ----------------------------------------------------------------------------
// iyfd_parser
// Byte-wise frame parser: header match, running sum, yaw capture, skip.
// ----------------------------------------------------------------------------
module iyfd_parser #(
  parameter int RESERVED_BYTES = iyfd_pkg::RESERVED_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [1:0]                  mode,
  input  logic [iyfd_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        chunk_last,
  input  logic [iyfd_pkg::BYTE_W-1:0] sync_first,
  input  logic [iyfd_pkg::BYTE_W-1:0] sync_second,
  output iyfd_pkg::iyfd_frame_t       frame
);
  import iyfd_pkg::*;

  localparam int PH_HDR1 = 0;
  localparam int PH_HDR2 = 1;
  localparam int PH_YAWL = 2 + RESERVED_BYTES;
  localparam int PH_YAWH = PH_YAWL + 1;
  localparam int PH_CHK  = PH_YAWL + 4;
  localparam int PH_W    = $clog2(PH_CHK + 1);

  logic [PH_W-1:0]   phase;
  logic [PH_W-1:0]   phase_eff;
  logic [BYTE_W-1:0] running_sum;
  logic [YAW_W-1:0]  yaw_bytes;
  logic              skip;
  logic              byte_take;

  // a phase past the checksum reads as waiting for the first header
  assign phase_eff = (phase > PH_W'(PH_CHK)) ? PH_W'(PH_HDR1) : phase;
  assign byte_take = accept && (mode == MODE_BYTE) && !skip;

  assign frame.chk = byte_take && (phase_eff == PH_W'(PH_CHK));
  assign frame.ok  = (running_sum == rx_byte);
  assign frame.yaw = yaw_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_W'(PH_HDR1);
      running_sum <= '0;
      yaw_bytes   <= '0;
      skip        <= 1'b0;
    end else if (accept && (mode == MODE_BYTE)) begin
      if (skip) begin
        if (chunk_last) skip <= 1'b0;
      end else if (phase_eff == PH_W'(PH_HDR1)) begin
        if (rx_byte == sync_first) begin
          running_sum <= rx_byte;
          phase       <= PH_W'(PH_HDR2);
        end else begin
          phase <= PH_W'(PH_HDR1);
        end
      end else if (phase_eff == PH_W'(PH_HDR2)) begin
        if (rx_byte == sync_second) begin
          running_sum <= running_sum + rx_byte;
          phase       <= PH_W'(PH_HDR2 + 1);
        end else begin
          phase <= PH_W'(PH_HDR1);
        end
      end else if (phase_eff == PH_W'(PH_CHK)) begin
        phase <= PH_W'(PH_HDR1);
        if (!chunk_last) skip <= 1'b1;
      end else begin
        if (phase_eff == PH_W'(PH_YAWL)) yaw_bytes[7:0] <= rx_byte;
        if (phase_eff == PH_W'(PH_YAWH)) yaw_bytes[15:8] <= rx_byte;
        running_sum <= running_sum + rx_byte;
        phase       <= phase_eff + PH_W'(1);
      end
    end
  end

endmodule

// ----- src/iyfd_divider.sv -----
// ----------------------------------------------------------------------------
// iyfd_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iyfd_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [iyfd_pkg::DVD_W-1:0] dividend,
  input  logic [iyfd_pkg::DVS_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [iyfd_pkg::DVD_W-1:0] quotient
);
  import iyfd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] acc;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial    = {rem, acc[DVD_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= dividend;
        rem  <= '0;
        cnt  <= CNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        // quotient bits shift in behind the dividend bits
        if (trial >= {1'b0, divisor}) begin
          rem <= diff[DVS_W-1:0];
          acc <= {acc[DVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[DVS_W-1:0];
          acc <= {acc[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/iyfd_tracker.sv -----
// ----------------------------------------------------------------------------
// iyfd_tracker
// Calibration, relative heading, yaw speed sequencer and result register.
// ----------------------------------------------------------------------------
module iyfd_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [1:0]                        mode,
  input  logic [iyfd_pkg::TIME_W-1:0]       time_ms,
  input  logic signed [iyfd_pkg::REF_W-1:0] new_reference,
  input  iyfd_pkg::iyfd_frame_t             frame,
  output logic                              idle,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [iyfd_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import iyfd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_RAD, ST_DIFF, ST_SCALE, ST_DSTART, ST_DIV, ST_EMIT
  } state_t;

  state_t state;

  logic                     ok_q;
  logic                     calib_pending;
  logic [2:0]               calib_seen;
  logic signed [REF_W-1:0]  reference_angle;
  logic signed [RAD_W-1:0]  previous_rad;
  logic [TIME_W-1:0]        previous_time;
  logic signed [RATE_W-1:0] held_rate;
  logic signed [YAW_W-1:0]  held_heading;

  logic [TIME_W-1:0]        time_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [RAD_W-1:0]  rad_q;
  logic [TIME_W-1:0]        gap_q;
  logic                     hold_q;
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [DVD_W-1:0]         dvd_q;

  logic signed [REF_W-1:0]  nowyaw;
  logic [2:0]               seen_inc;
  logic signed [PROD_W-1:0] rnd;
  logic signed [REF_W-1:0]  rad_diff;
  logic signed [REF_W-1:0]  rad_abs;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [DVD_W-1:0]         div_q;

  assign nowyaw    = -(REF_W'($signed(frame.yaw)));
  assign seen_inc  = calib_seen + 3'd1;
  assign rnd       = prod + PROD_W'(ROUND_HALF);
  assign rad_diff  = REF_W'(rad_q) - REF_W'(previous_rad);
  assign rad_abs   = (rad_diff < 0) ? -rad_diff : rad_diff;
  assign div_start = (state == ST_DSTART);
  assign idle      = (state == ST_IDLE);

  iyfd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_q),
    .divisor  (gap_q),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      ok_q            <= 1'b0;
      calib_pending   <= 1'b1;
      calib_seen      <= '0;
      reference_angle <= '0;
      previous_rad    <= '0;
      previous_time   <= '0;
      held_rate       <= '0;
      held_heading    <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_EMIT)) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (mode == MODE_RECAL)) calib_pending <= 1'b1;
          if (accept && (mode == MODE_SETREF)) reference_angle <= new_reference;
          if (frame.chk) begin
            ok_q <= frame.ok;
            if (frame.ok && !calib_pending) begin
              held_heading <= YAW_W'(nowyaw - reference_angle);
              time_q       <= time_ms;
              state        <= ST_MUL;
            end else begin
              state <= ST_EMIT;
              if (frame.ok) begin
                if (seen_inc == 3'(CALIB_FRAMES)) begin
                  calib_pending   <= 1'b0;
                  reference_angle <= nowyaw;
                  calib_seen      <= '0;
                end else begin
                  calib_seen <= seen_inc;
                end
              end
            end
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(held_heading) * PROD_W'(QUARTER_PI_Q16);
          state <= ST_RAD;
        end
        ST_RAD: begin
          // round half up, then floor by the arithmetic shift
          rad_q  <= rnd[31:16];
          gap_q  <= time_q - previous_time;
          hold_q <= (previous_time == '0) || (time_q == previous_time) ||
                    (previous_rad == '0);
          state  <= ST_DIFF;
        end
        ST_DIFF: begin
          neg_q         <= (rad_diff < 0);
          mag_q         <= rad_abs[MAG_W-1:0];
          previous_rad  <= rad_q;
          previous_time <= time_q;
          state         <= hold_q ? ST_EMIT : ST_SCALE;
        end
        ST_SCALE: begin
          dvd_q <= DVD_W'(mag_q) * DVD_W'(RATE_SCALE);
          state <= ST_DSTART;
        end
        ST_DSTART: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            held_rate <= neg_q ? -(RATE_W'(div_q)) : RATE_W'(div_q);
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {3'b000, previous_time, held_rate, previous_rad,
                         held_heading, calib_pending, ok_q};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy)
    else $error("divider not busy after start");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !accept)
    else $error("word accepted while a frame is in progress");

  a_calib_count: assert property (@(posedge clk) disable iff (rst)
    !calib_pending |-> (calib_seen == 3'd0))
    else $error("calibration count left over after reference latched");

endmodule

// ----- src/imu_yaw_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// imu_yaw_frame_decoder
// A word that completes no frame is just taken. A checksum word goes to ST_EMIT
// directly when it is bad or calibration is pending, through ST_MUL, ST_RAD
// and ST_DIFF when the heading is updated with the yaw speed held, and on
// through ST_SCALE, ST_DSTART and the 26-step bit-serial divider otherwise.
// s_tready is low from a checksum word until its result is registered.
// Reset (rst, synchronous): parser waits for a header, calibration pending.
// ----------------------------------------------------------------------------
module imu_yaw_frame_decoder #(
  parameter int RESERVED_BYTES = iyfd_pkg::RESERVED_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // cfg write port
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [iyfd_pkg::BYTE_W-1:0]       cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [iyfd_pkg::IN_DATA_W-1:0]    s_tdata,   // rx_byte, time_ms, new_reference
  input  logic [1:0]                        s_tuser,   // mode
  input  logic                              s_tlast,   // chunk_last
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [iyfd_pkg::OUT_DATA_W-1:0]   m_tdata    // checksum_ok, calibrating,
                                                       // heading_units, heading_rad_q13,
                                                       // yaw_rate_q13, update_time_ms
);
  import iyfd_pkg::*;

  logic [BYTE_W-1:0] sync_first;
  logic [BYTE_W-1:0] sync_second;
  logic              accept;
  logic              idle;
  iyfd_frame_t       frame;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  iyfd_parser #(
    .RESERVED_BYTES (RESERVED_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .mode        (s_tuser),
    .rx_byte     (s_tdata[7:0]),
    .chunk_last  (s_tlast),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .frame       (frame)
  );

  iyfd_tracker u_tracker (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .mode          (s_tuser),
    .time_ms       (s_tdata[39:8]),
    .new_reference ($signed(s_tdata[56:40])),
    .frame         (frame),
    .idle          (idle),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .m_tdata       (m_tdata)
  );

endmodule

// ----- tb/sv/tb_imu_yaw_frame_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_yaw_frame_decoder
// Drives serial words, commands and header settings into the yaw frame
// decoder and checks every frame result against a behavioural predictor.
// ----------------------------------------------------------------------------
module tb_imu_yaw_frame_decoder;
  import iyfd_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int SETTLE_CYCLES   = 50;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 160;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  // parser positions within a frame
  localparam int PH_FIRST    = 0;
  localparam int PH_SECOND   = 1;
  localparam int PH_RESERVED = 2;
  localparam int PH_YAW_LO   = PH_RESERVED + RESERVED_BYTES_DEF;
  localparam int PH_YAW_HI   = PH_YAW_LO + 1;
  localparam int PH_CHECK    = PH_YAW_LO + 4;
  localparam int FRAME_LEN   = PH_CHECK + 1;

  localparam int FRAME_GOOD    = 0;
  localparam int FRAME_BAD_SUM = 1;
  localparam int FRAME_BAD_HDR = 2;
  localparam int FRAME_CUT     = 3;

  typedef struct packed {
    logic [IN_DATA_W-BYTE_W-TIME_W-REF_W-1:0] pad;
    logic [REF_W-1:0]                         nref;
    logic [TIME_W-1:0]                        tms;
    logic [BYTE_W-1:0]                        rx;
  } rx_data_t;

  typedef struct {
    logic [1:0] mode;
    logic       last;
    rx_data_t   data;
  } rx_word_t;

  typedef struct packed {
    logic [OUT_DATA_W-TIME_W-RATE_W-RAD_W-YAW_W-3:0] pad;
    logic [TIME_W-1:0]                               tms;
    logic [RATE_W-1:0]                               rate;
    logic [RAD_W-1:0]                                rad;
    logic [YAW_W-1:0]                                hdg;
    logic                                            cal;
    logic                                            ok;
  } frame_result_t;

  typedef struct {
    rx_word_t      w;
    bit            typed;
    frame_result_t res;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_index = CFG_SYNC_FIRST;
  logic [BYTE_W-1:0]     cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [1:0]            s_tuser   = MODE_BYTE;
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  imu_yaw_frame_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // rx_byte, time_ms, new_reference
    .s_tuser  (s_tuser),   // mode
    .s_tlast  (s_tlast),   // chunk_last
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // checksum_ok, calibrating, heading_units,
                           // heading_rad_q13, yaw_rate_q13, update_time_ms
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder state as the predictor sees it
  logic [BYTE_W-1:0]        sync_first_q;
  logic [BYTE_W-1:0]        sync_second_q;
  logic [3:0]               phase_q;
  logic [7:0]               sum_q;
  logic [15:0]              yaw_q;
  logic                     skip_q;
  logic                     calib_q;
  logic [2:0]               calib_cnt_q;
  logic signed [REF_W-1:0]  ref_q;
  logic signed [RAD_W-1:0]  rad_q;
  logic [TIME_W-1:0]        time_q;
  logic signed [RATE_W-1:0] rate_q;
  logic signed [YAW_W-1:0]  hdg_q;

  frame_result_t pending_frames[$];
  stim_row_t     directed_rows[$];
  int            mismatches  = 0;
  int            idle_cycles = 0;
  bit            calm        = 1'b0;
  logic [31:0]   clock_ms    = '0;

  function automatic void reset_decoder_model();
    sync_first_q  = SYNC_FIRST_RST;
    sync_second_q = SYNC_SECOND_RST;
    phase_q       = 4'(PH_FIRST);
    sum_q         = '0;
    yaw_q         = '0;
    skip_q        = 1'b0;
    calib_q       = 1'b1;
    calib_cnt_q   = '0;
    ref_q         = '0;
    rad_q         = '0;
    time_q        = '0;
    rate_q        = '0;
    hdg_q         = '0;
  endfunction

  // returns 1 when the word completes a frame, with the result in r
  function automatic bit decode_word(input rx_word_t w, output frame_result_t r);
    logic [7:0]  b;
    logic [15:0] wrapped;
    logic [31:0] delta;
    longint      yaw_now;
    longint      rad_now;
    longint      rate_now;
    longint      gap;
    bit          good;
    b = w.data.rx;
    r = '0;
    if (w.mode == MODE_RECAL) begin
      calib_q = 1'b1;
      return 1'b0;
    end
    if (w.mode == MODE_SETREF) begin
      ref_q = w.data.nref;
      return 1'b0;
    end
    if (w.mode != MODE_BYTE) return 1'b0;
    if (skip_q) begin
      if (w.last) skip_q = 1'b0;
      return 1'b0;
    end
    if (phase_q > PH_CHECK) phase_q = 4'(PH_FIRST);
    if (phase_q == PH_FIRST) begin
      if (b == sync_first_q) begin
        sum_q   = b;
        phase_q = 4'(PH_SECOND);
      end
      return 1'b0;
    end
    if (phase_q == PH_SECOND) begin
      if (b == sync_second_q) begin
        sum_q   = sum_q + b;
        phase_q = 4'(PH_RESERVED);
      end else begin
        phase_q = 4'(PH_FIRST);
      end
      return 1'b0;
    end
    if (phase_q != PH_CHECK) begin
      if (phase_q == PH_YAW_LO) yaw_q[7:0] = b;
      else if (phase_q == PH_YAW_HI) yaw_q[15:8] = b;
      sum_q   = sum_q + b;
      phase_q = phase_q + 4'd1;
      return 1'b0;
    end
    good    = (sum_q == b);
    phase_q = 4'(PH_FIRST);
    if (!w.last) skip_q = 1'b1;
    if (good) begin
      yaw_now = -longint'($signed(yaw_q));
      if (calib_q) begin
        calib_cnt_q = calib_cnt_q + 3'd1;
        if (calib_cnt_q >= CALIB_FRAMES) begin
          calib_q     = 1'b0;
          ref_q       = yaw_now[REF_W-1:0];
          calib_cnt_q = '0;
        end
      end else begin
        // one turn is 65536 units, so the wrap is just the low half
        wrapped = yaw_now[15:0] - ref_q[15:0];
        rad_now = (longint'($signed(wrapped)) * QUARTER_PI_Q16 + ROUND_HALF) >>> 16;
        if (time_q != 0) begin
          delta = w.data.tms - time_q;
          if (delta != 0 && rad_q != 0) begin
            gap      = longint'(delta);
            rate_now = ((rad_now - longint'(rad_q)) * RATE_SCALE) / gap;
            rate_q   = rate_now[RATE_W-1:0];
          end
        end
        rad_q  = rad_now[RAD_W-1:0];
        time_q = w.data.tms;
        hdg_q  = wrapped;
      end
    end
    r.ok   = good;
    r.cal  = calib_q;
    r.hdg  = hdg_q;
    r.rad  = rad_q;
    r.rate = rate_q;
    r.tms  = time_q;
    return 1'b1;
  endfunction

  function automatic rx_word_t make_word(input logic [1:0] mode, input logic [7:0] rx,
                                         input logic last, input logic [31:0] tms,
                                         input logic [16:0] nref);
    rx_word_t w;
    w.mode      = mode;
    w.last      = last;
    w.data      = '0;
    w.data.rx   = rx;
    w.data.tms  = tms;
    w.data.nref = nref;
    return w;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_word(input rx_word_t w, input bit typed, input frame_result_t typed_res);
    int            wait_cycles;
    frame_result_t r;
    wait_cycles = draw_gap();
    if (wait_cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.mode;
    s_tlast  <= w.last;
    s_tdata  <= w.data;
    do @(posedge clk); while (!s_tready);
    if (decode_word(w, r)) pending_frames.push_back(typed ? typed_res : r);
  endtask

  task automatic send_plain(input logic [1:0] mode, input logic [7:0] rx, input logic last);
    send_word(make_word(mode, rx, last, clock_ms, 17'($urandom)), 1'b0, '0);
  endtask

  task automatic send_noise(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = ($urandom_range(0, 2) == 0) ? sync_first_q : 8'($urandom);
      send_plain(MODE_BYTE, b, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic send_frame(input int flavour);
    logic [7:0]  frame_bytes [FRAME_LEN];
    logic [15:0] yaw;
    logic [7:0]  sum;
    logic        last;
    int          count;
    int          tail;
    case ($urandom_range(0, 29))
      0:       clock_ms = '0;
      1:       clock_ms = $urandom;
      2:       clock_ms = 32'hFFFF_FFF0;
      default: clock_ms = clock_ms + $urandom_range(0, 20);
    endcase
    case ($urandom_range(0, 9))
      0:       yaw = 16'h8000;
      1:       yaw = 16'h7FFF;
      2:       yaw = 16'h0000;
      3:       yaw = 16'hFFFF;
      default: yaw = 16'($urandom);
    endcase
    frame_bytes[PH_FIRST]  = sync_first_q;
    frame_bytes[PH_SECOND] = sync_second_q;
    for (int i = PH_RESERVED; i < PH_CHECK; i++) frame_bytes[i] = 8'($urandom);
    frame_bytes[PH_YAW_LO] = yaw[7:0];
    frame_bytes[PH_YAW_HI] = yaw[15:8];
    sum = '0;
    for (int i = 0; i < PH_CHECK; i++) sum = sum + frame_bytes[i];
    frame_bytes[PH_CHECK] = sum;
    if (flavour == FRAME_BAD_SUM) frame_bytes[PH_CHECK] = sum + 8'($urandom_range(1, 255));
    if (flavour == FRAME_BAD_HDR) begin
      frame_bytes[PH_SECOND] = sync_second_q ^ 8'($urandom_range(1, 255));
    end
    count = (flavour == FRAME_CUT) ? $urandom_range(2, PH_CHECK) : FRAME_LEN;
    for (int i = 0; i < count; i++) begin
      clock_ms = clock_ms + $urandom_range(0, 1);
      last = (i == PH_CHECK) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
      send_plain(MODE_BYTE, frame_bytes[i], last);
      // rest of the chunk after a checksum word is dropped until its last word
      if (i == PH_CHECK && !last) begin
        tail = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        for (int j = 0; j < tail; j++) begin
          send_plain(MODE_BYTE, 8'($urandom), j == tail - 1);
        end
      end
    end
  endtask

  task automatic run_directed();
    logic [7:0]    bad_frame [FRAME_LEN];
    frame_result_t reset_bad;
    reset_bad     = '0;
    reset_bad.cal = 1'b1;
    bad_frame = '{SYNC_FIRST_RST, SYNC_SECOND_RST, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00};
    directed_rows.push_back('{make_word(MODE_SPARE, SYNC_FIRST_RST, 1'b1, 32'hFFFF_FFFF,
                                        17'h1FFFF), 1'b0, '0});
    directed_rows.push_back('{make_word(MODE_RECAL, 8'hFF, 1'b0, 32'd0, 17'h0), 1'b0, '0});
    directed_rows.push_back('{make_word(MODE_SETREF, 8'h00, 1'b0, 32'h8000_0000,
                                        17'h10000), 1'b0, '0});
    directed_rows.push_back('{make_word(MODE_SETREF, 8'h00, 1'b1, 32'd1, 17'h0FFFF),
                              1'b0, '0});
    directed_rows.push_back('{make_word(MODE_SETREF, 8'h00, 1'b0, 32'd2, 17'h0), 1'b0, '0});
    // a repeated first header fails as second header and is not taken again
    directed_rows.push_back('{make_word(MODE_BYTE, SYNC_FIRST_RST, 1'b0, 32'd3, 17'h0),
                              1'b0, '0});
    directed_rows.push_back('{make_word(MODE_BYTE, SYNC_FIRST_RST, 1'b0, 32'd4, 17'h0),
                              1'b0, '0});
    directed_rows.push_back('{make_word(MODE_BYTE, SYNC_SECOND_RST, 1'b0, 32'd5, 17'h0),
                              1'b0, '0});
    // bad checksum straight after reset: nothing held yet
    for (int i = 0; i < FRAME_LEN; i++) begin
      directed_rows.push_back('{make_word(MODE_BYTE, bad_frame[i], 1'b0, 32'(10 + i),
                                          17'h0), i == PH_CHECK, reset_bad});
    end
    // chunk tail is dropped up to its last word
    directed_rows.push_back('{make_word(MODE_BYTE, SYNC_FIRST_RST, 1'b0, 32'hFFFF_FFFF,
                                        17'h1FFFF), 1'b0, '0});
    directed_rows.push_back('{make_word(MODE_BYTE, 8'hFF, 1'b1, 32'd0, 17'h0), 1'b0, '0});
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].res);
    end
  endtask

  task automatic run_random(input int budget);
    int sent;
    int pick;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 24) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        send_frame(FRAME_GOOD);
        sent += FRAME_LEN;
      end else if (pick < 74) begin
        send_frame(FRAME_BAD_SUM);
        sent += FRAME_LEN;
      end else if (pick < 78) begin
        send_frame(FRAME_BAD_HDR);
        sent += FRAME_LEN;
      end else if (pick < 82) begin
        send_frame(FRAME_CUT);
        sent += FRAME_LEN / 2;
      end else if (pick < 88) begin
        send_noise($urandom_range(1, 3));
        sent += 2;
      end else if (pick < 92) begin
        send_plain(MODE_RECAL, 8'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 97) begin
        send_plain(MODE_SETREF, 8'($urandom), 1'($urandom));
        sent++;
      end else begin
        send_plain(MODE_SPARE, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_sync(input logic [7:0] first, input logic [7:0] second);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_data  <= first;
    @(posedge clk);
    sync_first_q = first;
    cfg_index <= CFG_SYNC_SECOND;
    cfg_data  <= second;
    @(posedge clk);
    sync_second_q = second;
    cfg_we <= 1'b0;
  endtask

  initial begin
    reset_decoder_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1:       program_sync(8'h00, 8'hFF);
          2:       program_sync(8'hFF, 8'h00);
          3:       program_sync(8'($urandom), 8'($urandom));
          default: program_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
        endcase
      end
      run_random(ITEMS_PER_PHASE);
    end
    drain();
    if (mismatches == 0) begin
      $display("tb_imu_yaw_frame_decoder passed");
    end else begin
      $display("tb_imu_yaw_frame_decoder failed");
    end
    $finish;
  end

  // result side
  initial begin
    int            wait_cycles;
    frame_result_t want;
    frame_result_t got;
    wait (rst == 1'b0);
    forever begin
      wait_cycles = draw_gap();
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata;
      if (pending_frames.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        compare_field("checksum_ok", want.ok, got.ok);
        compare_field("calibrating", want.cal, got.cal);
        compare_field("heading_units", want.hdg, got.hdg);
        compare_field("heading_rad_q13", want.rad, got.rad);
        compare_field("yaw_rate_q13", want.rate, got.rate);
        compare_field("update_time_ms", want.tms, got.tms);
      end
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_imu_yaw_frame_decoder failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
